### sv/lrbp_pkg.sv
// lrbp_pkg: shared types and constants of the line receiver buffer pool
// holds field widths, operation and status codes, control states and the result struct
// no dependencies
`default_nettype none

package lrbp_pkg;

	// fixed field widths of the transactions
	localparam int OP_W     = 2;
	localparam int DATA_W   = 8;
	localparam int BUF_W    = 3;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 4;
	localparam int MASK_W   = 8;

	// operation codes (code three decodes as a read)
	localparam logic [OP_W-1:0] OP_RECEIVE = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ    = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_STORED    = 4'd0;
	localparam logic [STATUS_W-1:0] ST_DONE      = 4'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED   = 4'd2;
	localparam logic [STATUS_W-1:0] ST_OVF_BEGIN = 4'd3;
	localparam logic [STATUS_W-1:0] ST_DISCARDED = 4'd4;
	localparam logic [STATUS_W-1:0] ST_RESYNC    = 4'd5;
	localparam logic [STATUS_W-1:0] ST_CR        = 4'd6;
	localparam logic [STATUS_W-1:0] ST_RELEASED  = 4'd7;
	localparam logic [STATUS_W-1:0] ST_READ      = 4'd8;

	// line control characters
	localparam logic [DATA_W-1:0] CH_LF = 8'd10;
	localparam logic [DATA_W-1:0] CH_CR = 8'd13;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SEARCH,
		S_RDWAIT,
		S_FINISH
	} ctrl_state_t;

	// one result transaction
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BUF_W-1:0]    done_buffer;
		logic [POS_W-1:0]    done_length;
		logic [DATA_W-1:0]   read_data;
		logic [MASK_W-1:0]   busy_mask;
	} res_t;

endpackage

`default_nettype wire

### sv/lrbp_if.sv
// lrbp_if: valid/ready channel interfaces for requests and results
// depends on lrbp_pkg for field widths
`default_nettype none

interface lrbp_req_if;
	import lrbp_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [DATA_W-1:0] rx_byte;
	logic [BUF_W-1:0]  buffer_select;
	logic [POS_W-1:0]  byte_select;

	modport source (output valid, operation, rx_byte, buffer_select, byte_select, input ready);
	modport sink (input valid, operation, rx_byte, buffer_select, byte_select, output ready);
endinterface

interface lrbp_rsp_if;
	import lrbp_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BUF_W-1:0]    done_buffer;
	logic [POS_W-1:0]    done_length;
	logic [DATA_W-1:0]   read_data;
	logic [MASK_W-1:0]   busy_mask;

	modport source (output valid, status, done_buffer, done_length, read_data, busy_mask,
		input ready);
	modport sink (input valid, status, done_buffer, done_length, read_data, busy_mask,
		output ready);
endinterface

`default_nettype wire

### sv/lrbp_store.sv
// lrbp_store: line byte memory, one write or read port, registered read data
// depends on lrbp_pkg for the data width
`default_nettype none

module lrbp_store #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic                       re,
	input  wire logic [ADDR_W-1:0]          addr,
	input  wire logic [lrbp_pkg::DATA_W-1:0] wdata,
	output logic      [lrbp_pkg::DATA_W-1:0] rdata
);
	import lrbp_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### sv/lrbp_ctrl.sv
// lrbp_ctrl: line assembly controller with round-robin free buffer scan
// depends on lrbp_pkg and lrbp_req_if; drives the line memory port
`default_nettype none

module lrbp_ctrl #(
	parameter int NUM_BUFFERS = 4,
	parameter int LINE_BYTES  = 64,
	parameter int ADDR_W      = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	lrbp_req_if.sink                         req,
	output logic                             mem_we,
	output logic                             mem_re,
	output logic      [ADDR_W-1:0]           mem_addr,
	output logic      [lrbp_pkg::DATA_W-1:0] mem_wdata,
	input  wire logic [lrbp_pkg::DATA_W-1:0] mem_rdata,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output lrbp_pkg::res_t                   res
);
	import lrbp_pkg::*;

	localparam int BUF_IDX_W  = $clog2(NUM_BUFFERS);
	localparam int BYTE_IDX_W = $clog2(LINE_BYTES);
	localparam int FILL_W     = $clog2(LINE_BYTES + 1);
	localparam logic [BUF_IDX_W-1:0] LAST_BUF = BUF_IDX_W'(NUM_BUFFERS - 1);
	localparam logic [FILL_W-1:0]    FILL_FULL = FILL_W'(LINE_BYTES);

	ctrl_state_t state_q, state_d;

	// latched request payload
	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] rx_q;
	logic [BUF_W-1:0]  bsel_q;
	logic [POS_W-1:0]  pos_q;

	// receiver state
	logic [NUM_BUFFERS-1:0] busy_q, busy_d;
	logic [BUF_IDX_W-1:0]   cur_q, cur_d;
	logic [FILL_W-1:0]      fill_q, fill_d;
	logic                   ovf_q, ovf_d;

	// free buffer scan
	logic [BUF_IDX_W-1:0] cand_q, cand_d;
	logic [BUF_IDX_W-1:0] cnt_q, cnt_d;
	logic                 post_q, post_d;

	// result fields under construction
	logic [STATUS_W-1:0] status_q, status_d;
	logic [BUF_W-1:0]    dbuf_q, dbuf_d;
	logic [POS_W-1:0]    dlen_q, dlen_d;
	logic [DATA_W-1:0]   rdata_q, rdata_d;

	logic [FILL_W-1:0] fill_inc;
	logic              rd_ok;
	logic              rel_ok;

	assign fill_inc = fill_q + FILL_W'(1);
	assign rel_ok   = {1'b0, bsel_q} < (BUF_W + 1)'(NUM_BUFFERS);
	assign rd_ok    = rel_ok && ({1'b0, pos_q} < (POS_W + 1)'(LINE_BYTES));

	// request payload capture
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q   <= req.operation;
			rx_q   <= req.rx_byte;
			bsel_q <= req.buffer_select;
			pos_q  <= req.byte_select;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			busy_q   <= '0;
			cur_q    <= '0;
			fill_q   <= '0;
			ovf_q    <= 1'b0;
			cand_q   <= '0;
			cnt_q    <= '0;
			post_q   <= 1'b0;
			status_q <= ST_STORED;
			dbuf_q   <= '0;
			dlen_q   <= '0;
			rdata_q  <= '0;
		end else begin
			state_q  <= state_d;
			busy_q   <= busy_d;
			cur_q    <= cur_d;
			fill_q   <= fill_d;
			ovf_q    <= ovf_d;
			cand_q   <= cand_d;
			cnt_q    <= cnt_d;
			post_q   <= post_d;
			status_q <= status_d;
			dbuf_q   <= dbuf_d;
			dlen_q   <= dlen_d;
			rdata_q  <= rdata_d;
		end
	end

	// next state, memory port and handshake
	always_comb begin
		state_d   = state_q;
		busy_d    = busy_q;
		cur_d     = cur_q;
		fill_d    = fill_q;
		ovf_d     = ovf_q;
		cand_d    = cand_q;
		cnt_d     = cnt_q;
		post_d    = post_q;
		status_d  = status_q;
		dbuf_d    = dbuf_q;
		dlen_d    = dlen_q;
		rdata_d   = rdata_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = {cur_q, fill_q[BYTE_IDX_W-1:0]};
		mem_wdata = rx_q;
		req.ready = 1'b0;
		res_valid = 1'b0;

		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					dbuf_d  = '0;
					dlen_d  = '0;
					rdata_d = '0;
					state_d = S_EXEC;
				end
			end

			S_EXEC: begin
				if (op_q == OP_RELEASE) begin
					if (rel_ok) begin
						busy_d[bsel_q[BUF_IDX_W-1:0]] = 1'b0;
					end
					status_d = ST_RELEASED;
					state_d  = S_FINISH;
				end else if (op_q[1]) begin
					// read, also taken for the unused fourth code
					mem_addr = {bsel_q[BUF_IDX_W-1:0], pos_q[BYTE_IDX_W-1:0]};
					mem_re   = rd_ok;
					status_d = ST_READ;
					state_d  = S_RDWAIT;
				end else if (ovf_q) begin
					// discard until end of line
					if (rx_q == CH_LF) begin
						ovf_d    = 1'b0;
						fill_d   = '0;
						status_d = ST_RESYNC;
					end else begin
						status_d = ST_DISCARDED;
					end
					state_d = S_FINISH;
				end else if (fill_q == FILL_FULL) begin
					// no buffer ready: retry the scan
					post_d  = 1'b0;
					cand_d  = cur_q;
					cnt_d   = '0;
					state_d = S_SEARCH;
				end else if (rx_q == CH_LF) begin
					// terminate line, mark busy, then scan for the next buffer
					mem_we    = 1'b1;
					mem_wdata = '0;
					dbuf_d    = BUF_W'(cur_q);
					dlen_d    = POS_W'(fill_q);
					busy_d[cur_q] = 1'b1;
					fill_d    = FILL_FULL;
					post_d    = 1'b1;
					cand_d    = cur_q;
					cnt_d     = '0;
					status_d  = ST_DONE;
					state_d   = S_SEARCH;
				end else if (rx_q == CH_CR) begin
					status_d = ST_CR;
					state_d  = S_FINISH;
				end else begin
					// store the byte
					mem_we = 1'b1;
					fill_d = fill_inc;
					if (fill_inc == FILL_FULL) begin
						ovf_d    = 1'b1;
						status_d = ST_OVF_BEGIN;
					end else begin
						status_d = ST_STORED;
					end
					state_d = S_FINISH;
				end
			end

			S_SEARCH: begin
				if (!busy_q[cand_q]) begin
					cur_d  = cand_q;
					fill_d = '0;
					if (!post_q && rx_q == CH_LF) begin
						// empty line in the buffer just found, then scan again
						mem_we    = 1'b1;
						mem_addr  = {cand_q, {BYTE_IDX_W{1'b0}}};
						mem_wdata = '0;
						dbuf_d    = BUF_W'(cand_q);
						dlen_d    = '0;
						busy_d[cand_q] = 1'b1;
						fill_d    = FILL_FULL;
						post_d    = 1'b1;
						cnt_d     = '0;
						status_d  = ST_DONE;
					end else begin
						status_d = post_q ? ST_DONE : ST_DROPPED;
						state_d  = S_FINISH;
					end
				end else if (cnt_q == LAST_BUF) begin
					// every buffer busy
					status_d = post_q ? ST_DONE : ST_DROPPED;
					state_d  = S_FINISH;
				end else begin
					cand_d = (cand_q == LAST_BUF) ? '0 : cand_q + BUF_IDX_W'(1);
					cnt_d  = cnt_q + BUF_IDX_W'(1);
				end
			end

			S_RDWAIT: begin
				rdata_d = rd_ok ? mem_rdata : '0;
				state_d = S_FINISH;
			end

			S_FINISH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// result fields
	always_comb begin
		res.status      = status_q;
		res.done_buffer = dbuf_q;
		res.done_length = dlen_q;
		res.read_data   = rdata_q;
		res.busy_mask   = MASK_W'(busy_q);
	end

endmodule

`default_nettype wire

### sv/line_receiver_buffer_pool_top.sv
// line_receiver_buffer_pool_top: serial line receiver over a pool of line buffers
// depends on lrbp_pkg, lrbp_if, lrbp_store and lrbp_ctrl
//
// Usage: the req channel carries one operation per transaction: receive a byte,
// release a buffer or read a stored byte. Every request gives exactly one result
// transaction on the rsp channel with status, the completed line's buffer and
// length, read data and the busy mask after the operation.
// Bytes are assembled into NUM_BUFFERS buffers of LINE_BYTES bytes in one
// memory; LF ends a line (zero terminated), CR is not stored.
// Sequence: release, CR, discard and plain store go from S_EXEC to S_FINISH, which
// offers the result to the output register; a read adds the memory read in
// S_RDWAIT. A line end adds the free buffer scan in S_SEARCH, one buffer per cycle
// from the buffer just closed. A byte arriving while no buffer is free adds a
// scan, plus a second scan when the retried LF completes an empty line. One
// request is processed at a time.
// The result sits in an output register: the next request is taken while it
// waits; if the receiver stalls, a finished second result holds the controller
// until the register frees up. Reset clears all busy bits, selects buffer zero
// and empties the line; buffer contents are undefined until written.
`default_nettype none

module line_receiver_buffer_pool_top #(
	parameter int NUM_BUFFERS = 4,
	parameter int LINE_BYTES  = 64
) (
	input wire logic  clk,
	input wire logic  arst_n,
	lrbp_req_if.sink  req,
	lrbp_rsp_if.source rsp
);
	import lrbp_pkg::*;

	localparam int BUF_IDX_W  = $clog2(NUM_BUFFERS);
	localparam int BYTE_IDX_W = $clog2(LINE_BYTES);
	localparam int ADDR_W     = BUF_IDX_W + BYTE_IDX_W;
	localparam int DEPTH      = NUM_BUFFERS * (1 << BYTE_IDX_W);

	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [DATA_W-1:0] mem_wdata;
	logic [DATA_W-1:0] mem_rdata;
	logic              res_valid;
	logic              res_ready;
	res_t              res;
	res_t              out_q;
	logic              out_valid_q;

	lrbp_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	lrbp_ctrl #(
		.NUM_BUFFERS (NUM_BUFFERS),
		.LINE_BYTES  (LINE_BYTES),
		.ADDR_W      (ADDR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register between controller and receiver
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.done_buffer = out_q.done_buffer;
	assign rsp.done_length = out_q.done_length;
	assign rsp.read_data   = out_q.read_data;
	assign rsp.busy_mask   = out_q.busy_mask;

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while previous one in flight");

	// a completed line leaves its buffer busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_DONE |-> rsp.busy_mask[rsp.done_buffer])
		else $error("completed line buffer not marked busy");

	// read data only on reads
	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_READ |-> rsp.read_data == '0)
		else $error("read data set on a non-read result");

	// no busy bits beyond the pool
	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.busy_mask >> NUM_BUFFERS) == '0)
		else $error("busy bit set outside the buffer pool");

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for line_receiver_buffer_pool_top, one request per result
// depends on lrbp_pkg, lrbp_if and the top level; drives random and directed traffic
// through a queue and checks every result against a line pool tracker

module tb;
	import lrbp_pkg::*;

	localparam int NUM_BUFFERS    = 4;
	localparam int LINE_BYTES     = 64;
	localparam int STORE_DEPTH    = NUM_BUFFERS * LINE_BYTES;
	localparam int LOOKAHEAD      = 0;
	localparam int TRACKER        = 1;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int LIMIT_CYCLES   = 400000;
	localparam logic [OP_W-1:0] OP_READ_ALT = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [DATA_W-1:0] rx_byte;
		logic [BUF_W-1:0]  buffer_select;
		logic [POS_W-1:0]  byte_select;
	} pool_op_t;

	logic clk;
	logic arst_n;

	lrbp_req_if req_ch ();
	lrbp_rsp_if rsp_ch ();

	line_receiver_buffer_pool_top #(
		.NUM_BUFFERS(NUM_BUFFERS),
		.LINE_BYTES (LINE_BYTES)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// two copies of the pool: one runs ahead while stimulus is built, one follows acceptance
	logic [DATA_W-1:0]      pool_mem [2][STORE_DEPTH];
	bit                     pool_written [2][STORE_DEPTH];
	logic [NUM_BUFFERS-1:0] pool_busy [2];
	int                     pool_cur [2];
	int                     pool_fill [2];
	bit                     pool_ovf [2];

	pool_op_t op_q[$];
	res_t     outcome_q[$];

	int queued        = 0;
	int errors        = 0;
	int checked_count = 0;
	int cycle_count   = 0;
	int send_idle_pct = 31;
	int recv_idle_pct = 68;
	int holdoff_req   = 0;
	int holdoff_ack   = 0;
	int holdoff_cnt   = 0;

	// round-robin search for a free buffer starting at the current one
	function automatic bit seek_free_buffer(input int who);
		int b;
		for (int i = 0; i < NUM_BUFFERS; i++) begin
			b = (pool_cur[who] + i) % NUM_BUFFERS;
			if (!pool_busy[who][b]) begin
				pool_cur[who] = b;
				pool_fill[who] = 0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// apply one operation to a pool copy and give the result it causes
	function automatic res_t pool_outcome(input int who, input pool_op_t it);
		res_t r;
		bit found;
		bit complete;
		int addr;
		r = '0;
		r.status = ST_DROPPED;
		complete = 1'b0;
		if (it.operation == OP_RELEASE) begin
			if (it.buffer_select < NUM_BUFFERS)
				pool_busy[who][it.buffer_select] = 1'b0;
			r.status = ST_RELEASED;
		end else if (it.operation != OP_RECEIVE) begin
			// read, code three decodes the same way
			if (it.buffer_select < NUM_BUFFERS && it.byte_select < LINE_BYTES)
				r.read_data = pool_mem[who][it.buffer_select * LINE_BYTES + it.byte_select];
			r.status = ST_READ;
		end else if (pool_ovf[who]) begin
			// overflow: drop everything up to the line end
			if (it.rx_byte == CH_LF) begin
				pool_ovf[who] = 1'b0;
				pool_fill[who] = 0;
				r.status = ST_RESYNC;
			end else begin
				r.status = ST_DISCARDED;
			end
		end else begin
			if (pool_fill[who] >= LINE_BYTES) begin
				// no buffer ready: retry the search, the byte itself is not kept
				found = seek_free_buffer(who);
				if (found && it.rx_byte == CH_LF)
					complete = 1'b1;
			end else if (it.rx_byte == CH_LF) begin
				complete = 1'b1;
			end else if (it.rx_byte == CH_CR) begin
				r.status = ST_CR;
			end else begin
				addr = pool_cur[who] * LINE_BYTES + pool_fill[who];
				pool_mem[who][addr] = it.rx_byte;
				pool_written[who][addr] = 1'b1;
				pool_fill[who]++;
				if (pool_fill[who] >= LINE_BYTES) begin
					pool_ovf[who] = 1'b1;
					r.status = ST_OVF_BEGIN;
				end else begin
					r.status = ST_STORED;
				end
			end
			// line end: terminate, mark busy, move on
			if (complete) begin
				r.done_buffer = BUF_W'(pool_cur[who]);
				r.done_length = POS_W'(pool_fill[who]);
				addr = pool_cur[who] * LINE_BYTES + pool_fill[who];
				pool_mem[who][addr] = '0;
				pool_written[who][addr] = 1'b1;
				pool_busy[who][pool_cur[who]] = 1'b1;
				pool_fill[who] = LINE_BYTES;
				void'(seek_free_buffer(who));
				r.status = ST_DONE;
			end
		end
		r.busy_mask = '0;
		r.busy_mask[NUM_BUFFERS-1:0] = pool_busy[who];
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch at result %0d: %s got %0d expected %0d", checked_count, field, got,
			want);
		errors++;
	endtask

	// stimulus building
	task automatic push_req(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] rxb,
		input logic [BUF_W-1:0] bsel, input logic [POS_W-1:0] pos);
		pool_op_t it;
		it.operation = op;
		it.rx_byte = rxb;
		it.buffer_select = bsel;
		it.byte_select = pos;
		void'(pool_outcome(LOOKAHEAD, it));
		op_q.push_back(it);
		queued++;
	endtask

	task automatic send_byte(input logic [DATA_W-1:0] b);
		push_req(OP_RECEIVE, b, BUF_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 63)));
	endtask

	task automatic send_line(input int len);
		logic [DATA_W-1:0] b;
		for (int i = 0; i < len; i++) begin
			b = DATA_W'($urandom_range(0, 255));
			if ($urandom_range(0, 11) == 0)
				b = CH_CR;
			else if (b == CH_LF)
				b = b ^ 8'h20;
			send_byte(b);
		end
		if ($urandom_range(0, 3) == 0)
			send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	// read only entries already written, or positions outside the pool
	task automatic send_read();
		logic [OP_W-1:0] op;
		int bsel;
		int pos;
		bit found;
		op = ($urandom_range(0, 7) == 0) ? OP_READ_ALT : OP_READ;
		found = 1'b0;
		bsel = 0;
		pos = 0;
		for (int k = 0; k < 16 && !found; k++) begin
			bsel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
				: $urandom_range(0, NUM_BUFFERS - 1);
			pos = $urandom_range(0, 63);
			if (bsel >= NUM_BUFFERS || pool_written[LOOKAHEAD][bsel * LINE_BYTES + pos])
				found = 1'b1;
		end
		if (!found)
			bsel = $urandom_range(NUM_BUFFERS, 7);
		push_req(op, DATA_W'($urandom_range(0, 255)), BUF_W'(bsel), POS_W'(pos));
	endtask

	task automatic run_random(input int count);
		int target;
		int pick;
		int busy_list[$];
		target = queued + count;
		while (queued < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_line($urandom_range(0, 12));
			end else if (pick < 39) begin
				send_line($urandom_range(13, 45));
			end else if (pick < 45) begin
				// long line: may overflow, then discard and resync
				send_line($urandom_range(60, 70));
			end else if (pick < 73) begin
				// consumer frees a line, mostly one that is really busy
				busy_list.delete();
				for (int b = 0; b < NUM_BUFFERS; b++)
					if (pool_busy[LOOKAHEAD][b])
						busy_list.push_back(b);
				if (busy_list.size() > 0 && $urandom_range(0, 3) != 0)
					push_req(OP_RELEASE, DATA_W'($urandom_range(0, 255)),
						BUF_W'(busy_list[$urandom_range(0, busy_list.size() - 1)]),
						POS_W'($urandom_range(0, 63)));
				else
					push_req(OP_RELEASE, DATA_W'($urandom_range(0, 255)),
						BUF_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 63)));
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4)) send_read();
			end else if (pick < 92) begin
				repeat ($urandom_range(1, 3)) send_byte(DATA_W'($urandom_range(0, 255)));
			end else begin
				// noise: any operation with any fields
				if ($urandom_range(0, 3) >= 2)
					send_read();
				else
					push_req(OP_W'($urandom_range(0, 1)), DATA_W'($urandom_range(0, 255)),
						BUF_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 63)));
			end
		end
	endtask

	task automatic wait_drained();
		while (op_q.size() != 0 || req_ch.valid || outcome_q.size() != 0)
			@(negedge clk);
	endtask

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_RECEIVE;
		req_ch.rx_byte = '0;
		req_ch.buffer_select = '0;
		req_ch.byte_select = '0;
		rsp_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// request driver: one transaction per accepted handshake
	always @(posedge clk) begin
		pool_op_t nxt;
		logic fire;
		fire = arst_n && req_ch.valid && req_ch.ready;
		if (fire)
			outcome_q.push_back(pool_outcome(TRACKER, {req_ch.operation, req_ch.rx_byte,
				req_ch.buffer_select, req_ch.byte_select}));
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (req_ch.valid && !fire) begin
			// hold the offered transaction
		end else if (op_q.size() != 0 &&
			(holdoff_cnt != 0 || $urandom_range(0, 99) >= send_idle_pct)) begin
			nxt = op_q.pop_front();
			req_ch.operation <= nxt.operation;
			req_ch.rx_byte <= nxt.rx_byte;
			req_ch.buffer_select <= nxt.buffer_select;
			req_ch.byte_select <= nxt.byte_select;
			req_ch.valid <= 1'b1;
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status = rsp_ch.status;
			got.done_buffer = rsp_ch.done_buffer;
			got.done_length = rsp_ch.done_length;
			got.read_data = rsp_ch.read_data;
			got.busy_mask = rsp_ch.busy_mask;
			if (outcome_q.size() == 0) begin
				report_mismatch("unrequested result, status", got.status, -1);
			end else begin
				want = outcome_q.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.done_buffer !== want.done_buffer)
					report_mismatch("done_buffer", got.done_buffer, want.done_buffer);
				if (got.done_length !== want.done_length)
					report_mismatch("done_length", got.done_length, want.done_length);
				if (got.read_data !== want.read_data)
					report_mismatch("read_data", got.read_data, want.read_data);
				if (got.busy_mask !== want.busy_mask)
					report_mismatch("busy_mask", got.busy_mask, want.busy_mask);
			end
			checked_count++;
		end
		rsp_ch.ready <= arst_n && holdoff_cnt == 0 && $urandom_range(0, 99) >= recv_idle_pct;
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (holdoff_req != holdoff_ack) begin
			holdoff_cnt <= HOLDOFF_CYCLES;
			holdoff_ack <= holdoff_req;
		end else if (holdoff_cnt != 0) begin
			holdoff_cnt <= holdoff_cnt - 1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		for (int w = 0; w < 2; w++) begin
			for (int a = 0; a < STORE_DEPTH; a++) begin
				pool_mem[w][a] = '0;
				pool_written[w][a] = 1'b0;
			end
			pool_busy[w] = '0;
			pool_cur[w] = 0;
			pool_fill[w] = 0;
			pool_ovf[w] = 1'b0;
		end

		// directed: byte extremes, CR, line end, reads, releases, no free buffer
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_CR);
		send_byte(CH_LF);
		push_req(OP_READ, 8'hFF, 3'd0, 6'd0);
		push_req(OP_READ, 8'h00, 3'd0, 6'd1);
		push_req(OP_READ, 8'h00, 3'd0, 6'd2);
		push_req(OP_READ, 8'h00, 3'd7, 6'd63);
		push_req(OP_READ_ALT, 8'h00, 3'd0, 6'd1);
		push_req(OP_RELEASE, 8'h00, 3'd5, 6'd0);
		push_req(OP_RELEASE, 8'h00, 3'd2, 6'd63);
		send_byte(CH_LF);
		send_byte(CH_LF);
		send_byte(CH_LF);
		send_byte(8'h41);
		push_req(OP_RELEASE, 8'h00, 3'd1, 6'd0);
		send_byte(8'h42);
		send_byte(CH_LF);
		push_req(OP_RELEASE, 8'h00, 3'd2, 6'd0);
		send_byte(CH_LF);
		send_byte(CH_CR);
		for (int b = 0; b < NUM_BUFFERS; b++)
			push_req(OP_RELEASE, 8'h00, BUF_W'(b), 6'd0);
		wait_drained();

		// sender sparse-ish, receiver slow, with one long receiver hold-off
		run_random(410);
		@(negedge clk);
		holdoff_req = holdoff_req + 1;
		wait_drained();

		// the other way round
		send_idle_pct = 68;
		recv_idle_pct = 31;
		run_random(420);
		wait_drained();

		// no idling at all
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(420);
		wait_drained();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && outcome_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
sv/lrbp_pkg.sv
sv/lrbp_if.sv
sv/lrbp_store.sv
sv/lrbp_ctrl.sv
sv/line_receiver_buffer_pool_top.sv
dv/tb.sv
